### rtl/gqpb_pkg.sv
// shared types and constants for the glyph quad packet builder
// no dependencies

package gqpb_pkg;

   localparam logic [1:0] OP_BEGIN = 2'd0;
   localparam logic [1:0] OP_CHAR  = 2'd1;
   localparam logic [1:0] OP_END   = 2'd2;

   localparam logic [2:0] REG_TEX_U_BASE     = 3'd0;
   localparam logic [2:0] REG_TEX_V_BASE     = 3'd1;
   localparam logic [2:0] REG_CLUT_WORD      = 3'd2;
   localparam logic [2:0] REG_PAGE_WORD      = 3'd3;
   localparam logic [2:0] REG_QUAD_COLOR     = 3'd4;
   localparam logic [2:0] REG_SPACE_ADVANCE  = 3'd5;
   localparam logic [2:0] REG_PACKET_BASE    = 3'd6;
   localparam logic [2:0] REG_LIST_HEAD_INIT = 3'd7;

   localparam logic [31:0] LINK_CODE           = 32'h0900_0000;
   localparam logic [31:0] QUAD_CODE           = 32'h2e00_0000;
   localparam logic [31:0] PACKET_BYTES        = 32'd40;
   localparam logic [7:0]  SPACE_ADVANCE_RESET = 8'd8;
   localparam logic [3:0]  LAST_SLOT           = 4'd9;
   localparam int          CSR_INDEX_W         = 3;
   localparam int          CSR_DATA_W          = 32;

   typedef struct packed {
      logic [1:0]        op;
      logic [15:0]       start_x;
      logic [15:0]       start_y;
      logic              is_space;
      logic              glyph_found;
      logic [7:0]        glyph_width;
      logic [7:0]        glyph_height;
      logic [7:0]        glyph_u;
      logic [7:0]        glyph_v;
      logic signed [7:0] glyph_advance;
      logic signed [7:0] offset_x;
      logic signed [7:0] offset_y;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [3:0]  word_slot;
      logic [31:0] word_address;
      logic [31:0] word_data;
      logic        last;
   } rsp_type;

   // one pending packet (or byte total) waiting to be streamed out
   typedef struct packed {
      logic        is_end;
      logic [3:0]  slot;
      logic [31:0] base;
      logic [31:0] link;
      logic [15:0] left;
      logic [15:0] right;
      logic [15:0] top;
      logic [15:0] bottom;
      logic [7:0]  u0;
      logic [7:0]  u1;
      logic [7:0]  v0;
      logic [7:0]  v1;
   } pkt_type;

endpackage

### rtl/glyph_quad_packet_builder_top.sv
// glyph quad packet builder: pen and list state, packet register, word streamer
// depends on gqpb_pkg
//
// a request word is captured in the pending packet register, its result words then
// in the output word register: ten packet words for a found glyph, one per cycle
// unless rsp_ready stalls, one byte total word for an end word, none for the rest
// reset: synchronous, clears pen and count, loads registers and list state to defaults

module glyph_quad_packet_builder_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  gqpb_pkg::req_type                     req_word,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output gqpb_pkg::rsp_type                     rsp_word,
   input  logic                                  csr_write,
   input  logic [gqpb_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [gqpb_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import gqpb_pkg::*;

   logic [7:0]  tex_u_base_ff, tex_u_base_in;
   logic [7:0]  tex_v_base_ff, tex_v_base_in;
   logic [15:0] clut_word_ff, clut_word_in;
   logic [15:0] page_word_ff, page_word_in;
   logic [23:0] quad_color_ff, quad_color_in;
   logic [7:0]  space_advance_ff, space_advance_in;
   logic [31:0] packet_base_ff, packet_base_in;
   logic [23:0] list_head_init_ff, list_head_init_in;

   logic [15:0] pen_x_ff, pen_x_in;
   logic [15:0] pen_y_ff, pen_y_in;
   logic [15:0] glyphs_ff, glyphs_in;
   logic [31:0] next_addr_ff, next_addr_in;
   logic [31:0] list_head_ff, list_head_in;

   logic        pend_valid_ff, pend_valid_in;
   pkt_type     pend_ff, pend_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        pend_move;
   logic        pend_done;
   logic        req_fire;
   logic [15:0] xs, ys;
   logic [7:0]  us, vs;
   logic [31:0] total;
   logic [31:0] word_data;

   assign pend_move = pend_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign pend_done = pend_move && (pend_ff.is_end || pend_ff.slot == LAST_SLOT);
   assign req_ready = !pend_valid_ff || pend_done;
   assign req_fire  = req_valid && req_ready;

   assign xs    = pen_x_ff + {{8{req_word.offset_x[7]}}, req_word.offset_x};
   assign ys    = pen_y_ff + {{8{req_word.offset_y[7]}}, req_word.offset_y};
   assign us    = tex_u_base_ff + req_word.glyph_u;
   assign vs    = tex_v_base_ff + req_word.glyph_v;
   assign total = {11'd0, glyphs_ff, 5'd0} + {13'd0, glyphs_ff, 3'd0};

   // packet word for the current slot
   always_comb begin
      case (pend_ff.slot)
         4'd0: word_data = pend_ff.link | LINK_CODE;
         4'd1: word_data = {8'd0, quad_color_ff} | QUAD_CODE;
         4'd2: word_data = {pend_ff.top | {16{pend_ff.left[15]}}, pend_ff.left};
         4'd3: word_data = {clut_word_ff, pend_ff.v0, pend_ff.u0};
         4'd4: word_data = {pend_ff.top | {16{pend_ff.right[15]}}, pend_ff.right};
         4'd5: word_data = {page_word_ff, pend_ff.v0, pend_ff.u1};
         4'd6: word_data = {pend_ff.bottom | {16{pend_ff.left[15]}}, pend_ff.left};
         4'd7: word_data = {16'd0, pend_ff.v1, pend_ff.u0};
         4'd8: word_data = {pend_ff.bottom | {16{pend_ff.right[15]}}, pend_ff.right};
         4'd9: word_data = {16'd0, pend_ff.v1, pend_ff.u1};
         default: word_data = '0;
      endcase
   end

   always_comb begin
      tex_u_base_in     = tex_u_base_ff;
      tex_v_base_in     = tex_v_base_ff;
      clut_word_in      = clut_word_ff;
      page_word_in      = page_word_ff;
      quad_color_in     = quad_color_ff;
      space_advance_in  = space_advance_ff;
      packet_base_in    = packet_base_ff;
      list_head_init_in = list_head_init_ff;
      pen_x_in          = pen_x_ff;
      pen_y_in          = pen_y_ff;
      glyphs_in         = glyphs_ff;
      next_addr_in      = next_addr_ff;
      list_head_in      = list_head_ff;
      pend_valid_in     = pend_valid_ff;
      pend_in           = pend_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_in            = rsp_ff;

      // stream out the pending packet
      if (pend_move) begin
         rsp_valid_in = 1'b1;
         if (pend_ff.is_end) begin
            rsp_in.kind         = 1'b1;
            rsp_in.word_slot    = 4'd0;
            rsp_in.word_address = '0;
            rsp_in.word_data    = pend_ff.link;
            rsp_in.last         = 1'b1;
         end else begin
            rsp_in.kind         = 1'b0;
            rsp_in.word_slot    = pend_ff.slot;
            rsp_in.word_address = pend_ff.base + {26'd0, pend_ff.slot, 2'b00};
            rsp_in.word_data    = word_data;
            rsp_in.last         = (pend_ff.slot == LAST_SLOT);
         end
         pend_in.slot = pend_ff.slot + 4'd1;
         if (pend_done) begin
            pend_valid_in = 1'b0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (req_fire) begin
         case (req_word.op)
            OP_BEGIN: begin
               pen_x_in  = req_word.start_x;
               pen_y_in  = req_word.start_y;
               glyphs_in = '0;
            end
            OP_CHAR: begin
               if (req_word.is_space) begin
                  pen_x_in = pen_x_ff + {{8{space_advance_ff[7]}}, space_advance_ff};
               end else if (req_word.glyph_found) begin
                  pend_valid_in  = 1'b1;
                  pend_in.is_end = 1'b0;
                  pend_in.slot   = '0;
                  pend_in.base   = next_addr_ff;
                  pend_in.link   = list_head_ff;
                  pend_in.left   = xs;
                  pend_in.right  = xs + {8'd0, req_word.glyph_width};
                  pend_in.top    = ys;
                  pend_in.bottom = ys + {8'd0, req_word.glyph_height};
                  pend_in.u0     = us;
                  pend_in.u1     = us + req_word.glyph_width;
                  pend_in.v0     = vs;
                  pend_in.v1     = vs + req_word.glyph_height;
                  list_head_in   = next_addr_ff;
                  next_addr_in   = next_addr_ff + PACKET_BYTES;
                  pen_x_in       = pen_x_ff
                                 + {{8{req_word.glyph_advance[7]}}, req_word.glyph_advance};
                  glyphs_in      = glyphs_ff + 16'd1;
               end
            end
            OP_END: begin
               pend_valid_in  = 1'b1;
               pend_in.is_end = 1'b1;
               pend_in.slot   = '0;
               pend_in.link   = total;
            end
            default: begin
            end
         endcase
      end

      if (csr_write) begin
         case (csr_index)
            REG_TEX_U_BASE:     tex_u_base_in    = csr_wdata[7:0];
            REG_TEX_V_BASE:     tex_v_base_in    = csr_wdata[7:0];
            REG_CLUT_WORD:      clut_word_in     = csr_wdata[15:0];
            REG_PAGE_WORD:      page_word_in     = csr_wdata[15:0];
            REG_QUAD_COLOR:     quad_color_in    = csr_wdata[23:0];
            REG_SPACE_ADVANCE:  space_advance_in = csr_wdata[7:0];
            REG_PACKET_BASE: begin
               packet_base_in = csr_wdata;
               next_addr_in   = csr_wdata;
            end
            REG_LIST_HEAD_INIT: begin
               list_head_init_in = csr_wdata[23:0];
               list_head_in      = {8'd0, csr_wdata[23:0]};
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_u_base_ff     <= '0;
         tex_v_base_ff     <= '0;
         clut_word_ff      <= '0;
         page_word_ff      <= '0;
         quad_color_ff     <= '0;
         space_advance_ff  <= SPACE_ADVANCE_RESET;
         packet_base_ff    <= '0;
         list_head_init_ff <= '0;
         pen_x_ff          <= '0;
         pen_y_ff          <= '0;
         glyphs_ff         <= '0;
         next_addr_ff      <= '0;
         list_head_ff      <= '0;
         pend_valid_ff     <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         tex_u_base_ff     <= tex_u_base_in;
         tex_v_base_ff     <= tex_v_base_in;
         clut_word_ff      <= clut_word_in;
         page_word_ff      <= page_word_in;
         quad_color_ff     <= quad_color_in;
         space_advance_ff  <= space_advance_in;
         packet_base_ff    <= packet_base_in;
         list_head_init_ff <= list_head_init_in;
         pen_x_ff          <= pen_x_in;
         pen_y_ff          <= pen_y_in;
         glyphs_ff         <= glyphs_in;
         next_addr_ff      <= next_addr_in;
         list_head_ff      <= list_head_in;
         pend_valid_ff     <= pend_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

`ifndef SYNTHESIS
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (pend_ff.slot <= LAST_SLOT))
      else $error("pending slot out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (req_fire && pend_valid_ff) |-> pend_done)
      else $error("pending packet overwritten");

   a_end_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind) |-> (rsp_ff.last && rsp_ff.word_slot == 4'd0))
      else $error("byte total word malformed");

   a_glyph_advance: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_word.op == OP_CHAR && !req_word.is_space && req_word.glyph_found
       && !csr_write) |=> (list_head_ff == $past(next_addr_ff)))
      else $error("list head not linked to packet");
`endif

endmodule

### sim/gqpb_packet_checker.sv
`timescale 1ns / 1ps
// response checker for the glyph quad packet builder: tracks csr writes and pen/list state,
// predicts the packet words of every accepted request word and compares the response channel
// depends on gqpb_pkg

module gqpb_packet_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  gqpb_pkg::req_type                   req_word,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  gqpb_pkg::rsp_type                   rsp_word,
   input  logic                                csr_write,
   input  logic [gqpb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [gqpb_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                  fail_count,
   output int                                  pending_words
);

   import gqpb_pkg::*;

   localparam logic KIND_PACKET = 1'b0;
   localparam logic KIND_TOTAL  = 1'b1;

   logic [7:0]  u_origin, v_origin, blank_advance;
   logic [15:0] palette_id, page_id;
   logic [23:0] tint;
   logic [15:0] cursor_x, cursor_y, glyph_total;
   logic [31:0] packet_addr, chain_head;
   rsp_type     awaited_words[$];
   rsp_type     oldest;

   task automatic report_mismatch(input string msg);
      if (fail_count < 40) $display("mismatch at %0t: %s", $realtime, msg);
      fail_count = fail_count + 1;
   endtask

   task automatic push_word(input logic kind, input logic [3:0] slot, input logic [31:0] addr,
                            input logic [31:0] data, input logic last);
      rsp_type w;
      w.kind         = kind;
      w.word_slot    = slot;
      w.word_address = addr;
      w.word_data    = data;
      w.last         = last;
      awaited_words.push_back(w);
   endtask

   task automatic queue_packet_words(input req_type item);
      logic [15:0] left_x, right_x, top_y, bottom_y;
      logic [7:0]  u0, u1, v0, v1;
      logic [31:0] packet [0:9];
      int k;
      case (item.op)
         OP_BEGIN: begin
            cursor_x    = item.start_x;
            cursor_y    = item.start_y;
            glyph_total = 16'd0;
         end
         OP_END: begin
            push_word(KIND_TOTAL, 4'd0, 32'd0, PACKET_BYTES * {16'd0, glyph_total}, 1'b1);
         end
         OP_CHAR: begin
            if (item.is_space) begin
               cursor_x = cursor_x + {{8{blank_advance[7]}}, blank_advance};
            end else if (item.glyph_found) begin
               left_x   = cursor_x + {{8{item.offset_x[7]}}, item.offset_x};
               right_x  = left_x + {8'd0, item.glyph_width};
               top_y    = cursor_y + {{8{item.offset_y[7]}}, item.offset_y};
               bottom_y = top_y + {8'd0, item.glyph_height};
               u0 = u_origin + item.glyph_u;
               u1 = u0 + item.glyph_width;
               v0 = v_origin + item.glyph_v;
               v1 = v0 + item.glyph_height;
               packet[0] = chain_head | LINK_CODE;
               packet[1] = {8'd0, tint} | QUAD_CODE;
               packet[2] = {top_y, 16'd0} | {{16{left_x[15]}}, left_x};
               packet[3] = {palette_id, v0, u0};
               packet[4] = {top_y, 16'd0} | {{16{right_x[15]}}, right_x};
               packet[5] = {page_id, v0, u1};
               packet[6] = {bottom_y, 16'd0} | {{16{left_x[15]}}, left_x};
               packet[7] = {16'd0, v1, u0};
               packet[8] = {bottom_y, 16'd0} | {{16{right_x[15]}}, right_x};
               packet[9] = {16'd0, v1, u1};
               for (k = 0; k < 10; k++) begin
                  push_word(KIND_PACKET, 4'(k), packet_addr + 32'(k * 4), packet[k],
                            4'(k) == LAST_SLOT);
               end
               chain_head  = packet_addr;
               cursor_x    = cursor_x + {{8{item.glyph_advance[7]}}, item.glyph_advance};
               packet_addr = packet_addr + PACKET_BYTES;
               glyph_total = glyph_total + 16'd1;
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         u_origin      = 8'd0;
         v_origin      = 8'd0;
         palette_id    = 16'd0;
         page_id       = 16'd0;
         tint          = 24'd0;
         blank_advance = SPACE_ADVANCE_RESET;
         cursor_x      = 16'd0;
         cursor_y      = 16'd0;
         glyph_total   = 16'd0;
         packet_addr   = 32'd0;
         chain_head    = 32'd0;
         fail_count    = 0;
         awaited_words.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_TEX_U_BASE:     u_origin = csr_wdata[7:0];
               REG_TEX_V_BASE:     v_origin = csr_wdata[7:0];
               REG_CLUT_WORD:      palette_id = csr_wdata[15:0];
               REG_PAGE_WORD:      page_id = csr_wdata[15:0];
               REG_QUAD_COLOR:     tint = csr_wdata[23:0];
               REG_SPACE_ADVANCE:  blank_advance = csr_wdata[7:0];
               REG_PACKET_BASE:    packet_addr = csr_wdata;
               REG_LIST_HEAD_INIT: chain_head = {8'd0, csr_wdata[23:0]};
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_words.size() == 0) begin
               report_mismatch($sformatf("unexpected word %h", rsp_word));
            end else begin
               oldest = awaited_words.pop_front();
               if (rsp_word.kind !== oldest.kind)
                  report_mismatch($sformatf("kind got %0d want %0d",
                                            rsp_word.kind, oldest.kind));
               if (rsp_word.word_slot !== oldest.word_slot)
                  report_mismatch($sformatf("slot got %0d want %0d",
                                            rsp_word.word_slot, oldest.word_slot));
               if (rsp_word.word_address !== oldest.word_address)
                  report_mismatch($sformatf("slot %0d address got %h want %h", oldest.word_slot,
                                            rsp_word.word_address, oldest.word_address));
               if (rsp_word.word_data !== oldest.word_data)
                  report_mismatch($sformatf("slot %0d data got %h want %h", oldest.word_slot,
                                            rsp_word.word_data, oldest.word_data));
               if (rsp_word.last !== oldest.last)
                  report_mismatch($sformatf("slot %0d last got %0d want %0d", oldest.word_slot,
                                            rsp_word.last, oldest.last));
            end
         end
         if (req_valid && req_ready) queue_packet_words(req_word);
      end
      pending_words = awaited_words.size();
   end

endmodule

### sim/tb_glyph_quad_packet_builder_top.sv
`timescale 1ns / 1ps
// testbench top for the glyph quad packet builder: clock, reset, csr setup, request and
// response traffic with random stalls, and the final verdict
// depends on gqpb_pkg, glyph_quad_packet_builder_top and gqpb_packet_checker

module tb_glyph_quad_packet_builder_top;

   import gqpb_pkg::*;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         CYCLE_LIMIT = 1000000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_word = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_word;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int   fail_count;
   int   pending_words;
   int   words_sent = 0;
   int   cycle_count = 0;
   logic sender_steady = 1'b0;
   logic receiver_hold = 1'b0;
   logic ready_level = 1'b0;
   int   ready_left = 0;
   int   ready_pick;

   glyph_quad_packet_builder_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   gqpb_packet_checker packet_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_word      (rsp_word),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_words (pending_words)
   );

   always #5 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   // response side stalls: short and long stalls, and stretches of full speed
   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_pick = $urandom_range(0, 19);
         if (ready_pick < 9) begin
            ready_level = 1'b1;
            ready_left  = $urandom_range(1, 12);
         end else if (ready_pick < 12) begin
            ready_level = 1'b1;
            ready_left  = $urandom_range(30, 80);
         end else if (ready_pick < 18) begin
            ready_level = 1'b0;
            ready_left  = $urandom_range(1, 3);
         end else begin
            ready_level = 1'b0;
            ready_left  = $urandom_range(8, 40);
         end
      end
      ready_left = ready_left - 1;
      rsp_ready <= ready_level && !receiver_hold && !reset;
   end

   // long receiver hold-off while requests keep coming, so the block backs up
   initial begin
      wait (words_sent >= 120);
      @(posedge clock);
      receiver_hold <= 1'b1;
      repeat (400) @(posedge clock);
      receiver_hold <= 1'b0;
   end

   function automatic int pick_gap();
      int roll;
      if (sender_steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic req_type random_word();
      logic [95:0] bits;
      bits = {$urandom, $urandom, $urandom};
      return bits[$bits(req_type)-1:0];
   endfunction

   function automatic req_type random_glyph();
      req_type item;
      item             = random_word();
      item.op          = OP_CHAR;
      item.is_space    = ($urandom_range(0, 9) == 0);
      item.glyph_found = ($urandom_range(0, 9) != 0);
      return item;
   endfunction

   function automatic req_type make_item(input logic [1:0] op, input logic [15:0] x,
                                         input logic [15:0] y, input logic space,
                                         input logic found, input logic [7:0] w,
                                         input logic [7:0] h, input logic [7:0] u,
                                         input logic [7:0] v, input logic [7:0] adv,
                                         input logic [7:0] ox, input logic [7:0] oy);
      req_type item;
      item.op            = op;
      item.start_x       = x;
      item.start_y       = y;
      item.is_space      = space;
      item.glyph_found   = found;
      item.glyph_width   = w;
      item.glyph_height  = h;
      item.glyph_u       = u;
      item.glyph_v       = v;
      item.glyph_advance = adv;
      item.offset_x      = ox;
      item.offset_y      = oy;
      return item;
   endfunction

   task automatic send_word(input req_type w);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      words_sent = words_sent + 1;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input logic [31:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic set_registers(input logic [31:0] u, input logic [31:0] v,
                                input logic [31:0] clut, input logic [31:0] page,
                                input logic [31:0] color, input logic [31:0] space,
                                input logic [31:0] base, input logic [31:0] head);
      write_reg(REG_TEX_U_BASE, u);
      write_reg(REG_TEX_V_BASE, v);
      write_reg(REG_CLUT_WORD, clut);
      write_reg(REG_PAGE_WORD, page);
      write_reg(REG_QUAD_COLOR, color);
      write_reg(REG_SPACE_ADVANCE, space);
      write_reg(REG_PACKET_BASE, base);
      write_reg(REG_LIST_HEAD_INIT, head);
   endtask

   // wait until every predicted word has come back and the block is quiet
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_words == 0);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      int phase;
      int phase_items;
      int glyphs;
      int k;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      set_registers(32'hf8, 32'h10, 32'hffff, 32'h8001, 32'hffffff, 32'h80,
                    32'hffff_ffe0, 32'hffffff);
      // glyph before any begin, then pen wrap and negative positions
      send_word(make_item(OP_CHAR, 16'h0, 16'h0, 1'b0, 1'b1, 8'hff, 8'hff, 8'hff, 8'hff,
                          8'h7f, 8'h80, 8'h80));
      send_word(make_item(OP_BEGIN, 16'hffff, 16'hffff, 1'b0, 1'b0, 8'h0, 8'h0, 8'h0, 8'h0,
                          8'h0, 8'h0, 8'h0));
      send_word(make_item(OP_CHAR, 16'h0, 16'h0, 1'b0, 1'b1, 8'hff, 8'hff, 8'hff, 8'hff,
                          8'h80, 8'h7f, 8'h7f));
      send_word(make_item(OP_CHAR, 16'h0, 16'h0, 1'b0, 1'b1, 8'h0, 8'h0, 8'h0, 8'h0,
                          8'h0, 8'h0, 8'h0));
      send_word(make_item(OP_CHAR, 16'h0, 16'h0, 1'b1, 1'b0, 8'h0, 8'h0, 8'h0, 8'h0,
                          8'h0, 8'h0, 8'h0));
      send_word(make_item(OP_CHAR, 16'h0, 16'h0, 1'b1, 1'b1, 8'hc8, 8'h20, 8'h11, 8'h22,
                          8'h05, 8'h01, 8'h02));
      send_word(make_item(OP_CHAR, 16'h0, 16'h0, 1'b0, 1'b0, 8'h4d, 8'h10, 8'h33, 8'h44,
                          8'h09, 8'h03, 8'h04));
      send_word(make_item(OP_CHAR, 16'h0, 16'h0, 1'b0, 1'b1, 8'h10, 8'h18, 8'h03, 8'h05,
                          8'h08, 8'hfe, 8'hfd));
      send_word(make_item(OP_UNUSED, 16'hffff, 16'hffff, 1'b1, 1'b1, 8'hff, 8'hff, 8'hff,
                          8'hff, 8'hff, 8'hff, 8'hff));
      send_word(make_item(OP_END, 16'h0, 16'h0, 1'b0, 1'b0, 8'h0, 8'h0, 8'h0, 8'h0,
                          8'h0, 8'h0, 8'h0));
      send_word(make_item(OP_END, 16'hffff, 16'hffff, 1'b1, 1'b1, 8'hff, 8'hff, 8'hff,
                          8'hff, 8'hff, 8'hff, 8'hff));
      send_word(make_item(OP_BEGIN, 16'h0, 16'h0, 1'b0, 1'b0, 8'h0, 8'h0, 8'h0, 8'h0,
                          8'h0, 8'h0, 8'h0));
      send_word(make_item(OP_END, 16'h0, 16'h0, 1'b0, 1'b0, 8'h0, 8'h0, 8'h0, 8'h0,
                          8'h0, 8'h0, 8'h0));
      send_word(make_item(OP_BEGIN, 16'h7ff0, 16'h8000, 1'b0, 1'b0, 8'h0, 8'h0, 8'h0, 8'h0,
                          8'h0, 8'h0, 8'h0));
      for (k = 0; k < 3; k++) send_word(random_glyph());
      send_word(make_item(OP_END, 16'h0, 16'h0, 1'b0, 1'b0, 8'h0, 8'h0, 8'h0, 8'h0,
                          8'h0, 8'h0, 8'h0));
      settle();

      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_registers(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h7f, 32'h0, 32'h0);
            1: set_registers(32'hff, 32'hff, 32'hffff, 32'hffff, 32'hffffff, 32'h0,
                             32'hffff_fffc, 32'hffffff);
            default: set_registers($urandom_range(0, 255), $urandom_range(0, 255),
                                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                                   $urandom_range(0, 24'hffffff), $urandom_range(0, 255),
                                   $urandom, $urandom_range(0, 24'hffffff));
         endcase
         sender_steady = (phase % 3 == 1);
         phase_items = 0;
         while (phase_items < 50) begin
            if ($urandom_range(0, 9) < 8) begin
               // a whole string: begin, characters, end
               glyphs = $urandom_range(0, 10);
               send_word(make_item(OP_BEGIN, 16'($urandom), 16'($urandom), 1'($urandom),
                                   1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                                   8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
               for (k = 0; k < glyphs; k++) send_word(random_glyph());
               send_word(make_item(OP_END, 16'($urandom), 16'($urandom), 1'($urandom),
                                   1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                                   8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
               phase_items = phase_items + glyphs + 2;
            end else begin
               send_word(random_word());
               phase_items = phase_items + 1;
            end
         end
         settle();
      end

      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### sim.f
rtl/gqpb_pkg.sv
rtl/glyph_quad_packet_builder_top.sv
sim/gqpb_packet_checker.sv
sim/tb_glyph_quad_packet_builder_top.sv
